>>> rtl/core/ppsc_pkg.sv
// ----------------------------------------------------------------------------
// ppsc_pkg
// Shared types, field widths and register indexes of the point projection
// and screen cull block.
// ----------------------------------------------------------------------------
package ppsc_pkg;

    localparam int S_TDATA_W  = 200;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 128;
    localparam int M_TUSER_W  = 2;
    localparam int APB_ADDR_W = 5;
    localparam int DIV_LANES  = 3;
    localparam int MAT_BANKS  = 4;
    localparam int MAT_COLS   = 4;

    typedef enum logic [2:0] {
        REG_CAM_X    = 3'd0,
        REG_CAM_Y    = 3'd1,
        REG_CAM_Z    = 3'd2,
        REG_W_MIN    = 3'd3,
        REG_MIRROR_X = 3'd4
    } reg_idx_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    typedef struct packed {
        logic        op;
        logic        relative_mode;
        logic [3:0]  mat_index;
        logic [31:0] mat_value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] vp_width;
        logic [15:0] vp_height;
        logic [15:0] vp_origin_x;
        logic [15:0] vp_origin_y;
    } in_item_t;

    // one matrix column in flight
    typedef struct packed {
        logic             vld;
        logic             load;
        logic             last;
        logic [1:0]       col;
        logic [2:0][31:0] pos;
        logic [3:0][15:0] vp;
    } tok_t;

    // transformed point, flagged valid with the token of the last column
    typedef struct packed {
        logic             vld;
        logic             load;
        logic [3:0][31:0] res;
        logic [3:0][15:0] vp;
    } xf_res_t;

    function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            sat_sub32 = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat_sub32 = d[31:0];
        end
    endfunction

    function automatic logic [31:0] neg_sat32(input logic [31:0] a);
        if (a == 32'h8000_0000) begin
            neg_sat32 = 32'h7FFF_FFFF;
        end else begin
            neg_sat32 = -a;
        end
    endfunction

endpackage

>>> rtl/core/ppsc_ram.sv
// ----------------------------------------------------------------------------
// ppsc_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ppsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem_reg[waddr] <= wdata;
        end
        if (ren) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ppsc_xform.sv
// ----------------------------------------------------------------------------
// ppsc_xform
// Matrix store and transform: four row banks, one column read per cycle unless stalled,
// three multiplies and a saturating accumulate per column.
// ----------------------------------------------------------------------------
module ppsc_xform #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  ppsc_pkg::in_item_t in_item,
    output logic               in_ready,
    input  logic [31:0]        cam_x,
    input  logic [31:0]        cam_y,
    input  logic [31:0]        cam_z,
    output ppsc_pkg::xf_res_t  xf_out
);
    import ppsc_pkg::*;

    localparam int AW = 66 - FRAC_BITS;

    logic             busy_reg;
    logic             ld_reg;
    logic [1:0]       col_reg;
    logic [2:0][31:0] pos_reg;
    logic [3:0][15:0] vp_reg;

    logic  last_now;
    logic  accept;
    tok_t  front_tok;
    tok_t  tok_rd_reg;
    tok_t  tok_mul_reg;
    tok_t  acc_tok_reg;

    logic [31:0]        rd_data [MAT_BANKS];
    logic signed [63:0] prod_reg [3];
    logic signed [63:0] prod_next [3];
    logic [31:0]        bias_reg;
    logic [3:0][31:0]   res_reg;
    logic [AW-1:0]      acc;
    logic [AW-32:0]     acc_hi;
    logic [31:0]        acc_sat;
    logic signed [63:0] sh [3];

    assign last_now = ld_reg | (col_reg == 2'd3);
    assign in_ready = adv & (~busy_reg | last_now);
    assign accept   = in_valid & in_ready;

    // loads write straight into the bank; the read port walks the columns
    for (genvar b = 0; b < MAT_BANKS; b++) begin : g_bank
        ppsc_ram #(.WIDTH(32), .DEPTH(MAT_COLS)) u_ram (
            .aclk  (aclk),
            .wen   (accept && in_item.op == OP_LOAD && in_item.mat_index[3:2] == 2'(b)),
            .waddr (in_item.mat_index[1:0]),
            .wdata (in_item.mat_value),
            .ren   (adv),
            .raddr (col_reg),
            .rdata (rd_data[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= 2'd0;
        end else if (adv) begin
            if (accept) begin
                busy_reg <= 1'b1;
                col_reg  <= 2'd0;
            end else if (busy_reg && last_now) begin
                busy_reg <= 1'b0;
            end else if (busy_reg) begin
                col_reg <= col_reg + 2'd1;
            end
        end
        if (accept) begin
            ld_reg <= (in_item.op == OP_LOAD);
            if (in_item.relative_mode) begin
                pos_reg <= {in_item.pos_z, in_item.pos_y, in_item.pos_x};
            end else begin
                pos_reg <= {sat_sub32(in_item.pos_z, cam_z),
                            sat_sub32(in_item.pos_y, cam_y),
                            sat_sub32(in_item.pos_x, cam_x)};
            end
            vp_reg <= {in_item.vp_origin_y, in_item.vp_origin_x,
                       in_item.vp_height, in_item.vp_width};
        end
    end

    always_comb begin
        front_tok.vld  = busy_reg;
        front_tok.load = ld_reg;
        front_tok.last = last_now;
        front_tok.col  = col_reg;
        front_tok.pos  = pos_reg;
        front_tok.vp   = vp_reg;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_next[i] = signed'(tok_rd_reg.pos[i]) * signed'(rd_data[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh[i] = prod_reg[i] >>> FRAC_BITS;
        end
        acc = {{(AW-32){bias_reg[31]}}, bias_reg} + sh[0][AW-1:0] + sh[1][AW-1:0]
            + sh[2][AW-1:0];
        acc_hi = acc[AW-1:31];
        if ((&acc_hi) || !(|acc_hi)) begin
            acc_sat = acc[31:0];
        end else begin
            acc_sat = acc[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_rd_reg.vld  <= 1'b0;
            tok_mul_reg.vld <= 1'b0;
            acc_tok_reg.vld <= 1'b0;
        end else if (adv) begin
            tok_rd_reg.vld  <= front_tok.vld;
            tok_mul_reg.vld <= tok_rd_reg.vld;
            acc_tok_reg.vld <= tok_mul_reg.vld;
        end
        if (adv) begin
            tok_rd_reg.load  <= front_tok.load;
            tok_rd_reg.last  <= front_tok.last;
            tok_rd_reg.col   <= front_tok.col;
            tok_rd_reg.pos   <= front_tok.pos;
            tok_rd_reg.vp    <= front_tok.vp;
            tok_mul_reg.load <= tok_rd_reg.load;
            tok_mul_reg.last <= tok_rd_reg.last;
            tok_mul_reg.col  <= tok_rd_reg.col;
            tok_mul_reg.pos  <= tok_rd_reg.pos;
            tok_mul_reg.vp   <= tok_rd_reg.vp;
            acc_tok_reg.load <= tok_mul_reg.load;
            acc_tok_reg.last <= tok_mul_reg.last;
            acc_tok_reg.col  <= tok_mul_reg.col;
            acc_tok_reg.pos  <= tok_mul_reg.pos;
            acc_tok_reg.vp   <= tok_mul_reg.vp;
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            bias_reg <= rd_data[3];
            if (tok_mul_reg.vld && !tok_mul_reg.load) begin
                res_reg[tok_mul_reg.col] <= acc_sat;
            end
        end
    end

    always_comb begin
        xf_out.vld  = acc_tok_reg.vld & acc_tok_reg.last;
        xf_out.load = acc_tok_reg.load;
        xf_out.res  = res_reg;
        xf_out.vp   = acc_tok_reg.vp;
    end

endmodule

>>> rtl/core/ppsc_div.sv
// ----------------------------------------------------------------------------
// ppsc_div
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor, with a side tag carried alongside.
// ----------------------------------------------------------------------------
module ppsc_div #(
    parameter int NB   = 48,
    parameter int TAGW = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_vld,
    input  logic [NB-1:0]   in_num [ppsc_pkg::DIV_LANES],
    input  logic [31:0]     in_den,
    input  logic [TAGW-1:0] in_tag,
    output logic            out_vld,
    output logic [NB-1:0]   out_q [ppsc_pkg::DIV_LANES],
    output logic [TAGW-1:0] out_tag
);
    import ppsc_pkg::*;

    logic            vld_reg [NB+1];
    logic [31:0]     den_reg [NB+1];
    logic [TAGW-1:0] tag_reg [NB+1];
    logic [NB-1:0]   nq_reg  [NB+1][DIV_LANES];
    logic [31:0]     rem_reg [NB+1][DIV_LANES];

    logic [NB-1:0]   nq_next  [NB][DIV_LANES];
    logic [31:0]     rem_next [NB][DIV_LANES];
    logic [32:0]     r2       [NB][DIV_LANES];
    logic [32:0]     diff     [NB][DIV_LANES];

    always_comb begin
        for (int s = 0; s < NB; s++) begin
            for (int l = 0; l < DIV_LANES; l++) begin
                r2[s][l]   = {rem_reg[s][l], nq_reg[s][l][NB-1]};
                diff[s][l] = r2[s][l] - {1'b0, den_reg[s]};
                if (r2[s][l] >= {1'b0, den_reg[s]}) begin
                    rem_next[s][l] = diff[s][l][31:0];
                    nq_next[s][l]  = {nq_reg[s][l][NB-2:0], 1'b1};
                end else begin
                    rem_next[s][l] = r2[s][l][31:0];
                    nq_next[s][l]  = {nq_reg[s][l][NB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NB; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s <= NB; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
        if (adv) begin
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
            for (int l = 0; l < DIV_LANES; l++) begin
                nq_reg[0][l]  <= in_num[l];
                rem_reg[0][l] <= 32'd0;
            end
            for (int s = 1; s <= NB; s++) begin
                den_reg[s] <= den_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
                for (int l = 0; l < DIV_LANES; l++) begin
                    nq_reg[s][l]  <= nq_next[s-1][l];
                    rem_reg[s][l] <= rem_next[s-1][l];
                end
            end
        end
    end

    assign out_vld = vld_reg[NB];
    assign out_tag = tag_reg[NB];
    always_comb begin
        for (int l = 0; l < DIV_LANES; l++) begin
            out_q[l] = nq_reg[NB][l];
        end
    end

endmodule

>>> rtl/core/point_projection_screen_cull_top.sv
// ----------------------------------------------------------------------------
// point_projection_screen_cull_top
// Projects points through a stored 4x4 matrix onto a viewport and culls
// them against it; matrix entries are loaded through the input stream.
//
//   channel   | direction | contents
//   s_*       | in        | load entry or point to project, one per transaction
//   m_*       | out       | one result per input transaction
//   apb       | in/out    | camera position, w threshold, mirror flag
//
// a point holds the input while its four matrix columns are read, one column
// read per cycle while not stalled, from four row banks; a load releases it
// without a column walk; results then pass the bit-per-stage divider
// aresetn is synchronous; matrix contents are not cleared by reset
// the whole pipeline holds while a result waits on m_tready
// ----------------------------------------------------------------------------
module point_projection_screen_cull_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppsc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mat_index, mat_value, pos_x, pos_y, pos_z, vp_width, vp_height,
    // vp_origin_x, vp_origin_y, zero pad
    input  logic [ppsc_pkg::S_TDATA_W-1:0]  s_tdata,
    // op, relative_mode
    input  logic [ppsc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // screen_x, screen_y, depth_z, clip_w
    output logic [ppsc_pkg::M_TDATA_W-1:0]  m_tdata,
    // projected, on_screen
    output logic [ppsc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import ppsc_pkg::*;

    localparam int NB = 32 + FRAC_BITS;
    localparam int LW = 18 + FRAC_BITS;
    localparam int XW = 52;
    localparam logic signed [63:0] NV64 = -64'sd1000 * (64'sd1 <<< FRAC_BITS);
    localparam logic [31:0] NOT_VIS = NV64[31:0];
    localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [XW-1:0] MARG = XW'(64'sd8 <<< FRAC_BITS);

    typedef struct packed {
        logic          load;
        logic          proj;
        logic [31:0]   w;
        logic [15:0]   sxz;
        logic [15:0]   syz;
        logic [LW-1:0] vleft;
        logic [LW-1:0] vtop;
        logic [2:0]    neg;
    } tag_t;

    localparam int TAGW = $bits(tag_t);

    logic [31:0] cam_x_reg, cam_y_reg, cam_z_reg, w_min_reg;
    logic        mirror_reg;
    logic        cfg_wr;
    logic        adv;

    in_item_t item;
    xf_res_t  xr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            w_min_reg  <= '0;
            mirror_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[4:2]))
                REG_CAM_X:    cam_x_reg  <= pwdata;
                REG_CAM_Y:    cam_y_reg  <= pwdata;
                REG_CAM_Z:    cam_z_reg  <= pwdata;
                REG_W_MIN:    w_min_reg  <= pwdata;
                REG_MIRROR_X: mirror_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_CAM_X:    prdata = cam_x_reg;
            REG_CAM_Y:    prdata = cam_y_reg;
            REG_CAM_Z:    prdata = cam_z_reg;
            REG_W_MIN:    prdata = w_min_reg;
            REG_MIRROR_X: prdata = {31'd0, mirror_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- transform ----------------
    always_comb begin
        item.op            = s_tuser[0];
        item.relative_mode = s_tuser[1];
        item.mat_index     = s_tdata[3:0];
        item.mat_value     = s_tdata[35:4];
        item.pos_x         = s_tdata[67:36];
        item.pos_y         = s_tdata[99:68];
        item.pos_z         = s_tdata[131:100];
        item.vp_width      = s_tdata[147:132];
        item.vp_height     = s_tdata[163:148];
        item.vp_origin_x   = s_tdata[179:164];
        item.vp_origin_y   = s_tdata[195:180];
    end

    ppsc_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_item  (item),
        .in_ready (s_tready),
        .cam_x    (cam_x_reg),
        .cam_y    (cam_y_reg),
        .cam_z    (cam_z_reg),
        .xf_out   (xr)
    );

    // ---------------- divider setup ----------------
    logic [31:0]        cx [3];
    logic [31:0]        mag [3];
    logic [NB-1:0]      num [DIV_LANES];
    logic [31:0]        den;
    logic signed [15:0] vpw, vph, vox, voy, sxz, syz, oxq, oyq;
    tag_t               tag_in;

    always_comb begin
        cx[0] = mirror_reg ? neg_sat32(xr.res[0]) : xr.res[0];
        cx[1] = xr.res[1];
        cx[2] = xr.res[2];
        den   = xr.res[3][31] ? -xr.res[3] : xr.res[3];
        for (int l = 0; l < DIV_LANES; l++) begin
            mag[l] = cx[l][31] ? -cx[l] : cx[l];
            num[l] = {mag[l], {FRAC_BITS{1'b0}}};
        end
        vpw = signed'(xr.vp[0]);
        vph = signed'(xr.vp[1]);
        vox = signed'(xr.vp[2]);
        voy = signed'(xr.vp[3]);
        // halves and quarters truncate toward zero
        sxz = (vpw + signed'({15'd0, vpw[15]})) >>> 1;
        syz = (vph + signed'({15'd0, vph[15]})) >>> 1;
        oxq = (vox + signed'({14'd0, {2{vox[15]}}})) >>> 2;
        oyq = (voy + signed'({14'd0, {2{voy[15]}}})) >>> 2;
        tag_in.load  = xr.load;
        tag_in.proj  = !xr.load && (signed'(xr.res[3]) > signed'(w_min_reg))
                       && (xr.res[3] != 32'd0);
        tag_in.w     = xr.res[3];
        tag_in.sxz   = sxz;
        tag_in.syz   = syz;
        tag_in.vleft = (LW'(oxq) <<< FRAC_BITS) - (LW'(sxz) <<< (FRAC_BITS - 1));
        tag_in.vtop  = (LW'(oyq) <<< FRAC_BITS) - (LW'(syz) <<< (FRAC_BITS - 1));
        for (int l = 0; l < DIV_LANES; l++) begin
            tag_in.neg[l] = cx[l][31] ^ xr.res[3][31];
        end
    end

    logic          dv_vld;
    logic [NB-1:0] dv_q [DIV_LANES];
    logic [TAGW-1:0] dv_tag_bits;
    tag_t          dv_tag;

    ppsc_div #(.NB(NB), .TAGW(TAGW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (xr.vld),
        .in_num  (num),
        .in_den  (den),
        .in_tag  (tag_in),
        .out_vld (dv_vld),
        .out_q   (dv_q),
        .out_tag (dv_tag_bits)
    );

    assign dv_tag = tag_t'(dv_tag_bits);

    // ---------------- viewport map ----------------
    logic [31:0]        qs [DIV_LANES];
    logic signed [33:0] ax, ay;
    logic signed [49:0] prodx_next, prody_next;

    always_comb begin
        for (int l = 0; l < DIV_LANES; l++) begin
            if (!dv_tag.neg[l]) begin
                qs[l] = (|dv_q[l][NB-1:31]) ? 32'h7FFF_FFFF : dv_q[l][31:0];
            end else if ((|dv_q[l][NB-1:32]) || (dv_q[l][31] && (|dv_q[l][30:0]))) begin
                qs[l] = 32'h8000_0000;
            end else begin
                qs[l] = -dv_q[l][31:0];
            end
        end
        ax = 34'(signed'(qs[0])) + ONE34;
        ay = ONE34 - 34'(signed'(qs[1]));
        prodx_next = ax * signed'(dv_tag.sxz);
        prody_next = ay * signed'(dv_tag.syz);
    end

    logic               fn_vld_reg;
    tag_t               fn_tag_reg;
    logic signed [49:0] prodx_reg, prody_reg;
    logic [31:0]        dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fn_vld_reg <= 1'b0;
        end else if (adv) begin
            fn_vld_reg <= dv_vld;
        end
        if (adv) begin
            fn_tag_reg <= dv_tag;
            prodx_reg  <= prodx_next;
            prody_reg  <= prody_next;
            dz_reg     <= qs[2];
        end
    end

    logic signed [XW-1:0] xv, yv, lo_x, hi_x, lo_y, hi_y;
    logic                 vis;
    logic [31:0]          sx_sat, sy_sat;
    logic [XW-32:0]       xhi, yhi;

    always_comb begin
        xv   = XW'(prodx_reg >>> 1) + XW'(signed'(fn_tag_reg.vleft));
        yv   = XW'(prody_reg >>> 1) + XW'(signed'(fn_tag_reg.vtop));
        lo_x = XW'(signed'(fn_tag_reg.vleft)) - MARG;
        lo_y = XW'(signed'(fn_tag_reg.vtop)) - MARG;
        hi_x = (XW'(signed'(fn_tag_reg.sxz)) <<< FRAC_BITS)
               + XW'(signed'(fn_tag_reg.vleft)) + MARG;
        hi_y = (XW'(signed'(fn_tag_reg.syz)) <<< FRAC_BITS)
               + XW'(signed'(fn_tag_reg.vtop)) + MARG;
        vis  = fn_tag_reg.proj && (lo_x < xv) && (xv < hi_x) && (lo_y < yv) && (yv < hi_y);
        xhi  = xv[XW-1:31];
        yhi  = yv[XW-1:31];
        if ((&xhi) || !(|xhi)) begin
            sx_sat = xv[31:0];
        end else begin
            sx_sat = xv[XW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if ((&yhi) || !(|yhi)) begin
            sy_sat = yv[31:0];
        end else begin
            sy_sat = yv[XW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // ---------------- output register ----------------
    logic                 out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;

    assign adv = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= fn_vld_reg;
        end
        if (adv) begin
            if (fn_tag_reg.load) begin
                out_data_reg <= '0;
                out_user_reg <= '0;
            end else if (!fn_tag_reg.proj) begin
                out_data_reg <= {32'd0, 32'd0, NOT_VIS, NOT_VIS};
                out_user_reg <= '0;
            end else begin
                out_data_reg <= {fn_tag_reg.w, dz_reg,
                                 vis ? sy_sat : NOT_VIS, vis ? sx_sat : NOT_VIS};
                out_user_reg <= {vis, 1'b1};
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> rtl/core/ppsc_checker.sv
// ----------------------------------------------------------------------------
// ppsc_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ppsc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ppsc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ppsc_pkg::M_TUSER_W-1:0] m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // visible points are always projected ones
    a_vis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("on_screen without projected");

    // unprojected results carry zero depth and w
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[127:64] == 64'd0)
        else $error("depth or w set on unprojected result");

endmodule

bind point_projection_screen_cull_top ppsc_checker u_ppsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
